// ----- rtl/core/sap_pkg.sv -----
// shared widths, constants and register codes of the servo angle pid step block
`timescale 1ns / 1ps
`default_nettype none
package sap_pkg;

  localparam int POT_W     = 10;
  localparam int ANGLE_W   = 16;
  localparam int MEAS_W    = 15;
  localparam int DRIVE_W   = 14;
  localparam int GAIN_W    = 16;
  localparam int INTEG_W   = 32;
  localparam int DERIV_W   = 21;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 22;
  localparam int MUL_W     = 56;
  localparam int ACC_W     = 40;
  localparam int DIV_NUM_W = 29;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P = 2'd0,
    CFG_GAIN_I = 2'd1,
    CFG_GAIN_D = 2'd2
  } cfg_idx_t;

  localparam logic [POT_W-1:0] POT_LO = 10'd50;
  localparam logic [POT_W-1:0] POT_HI = 10'd1000;
  localparam logic [POT_W-1:0] ADC_LO = 10'd200;
  localparam logic [POT_W-1:0] ADC_HI = 10'd800;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT     = 16'sd11520;
  localparam logic signed [ANGLE_W-1:0] NEG_ANGLE_LIMIT = -16'sd11520;
  localparam logic signed [ANGLE_W-1:0] DEADBAND        = 16'sd512;
  localparam logic signed [ANGLE_W-1:0] NEG_DEADBAND    = -16'sd512;

  localparam logic signed [ACC_W-1:0] DRIVE_LIMIT     = 40'sd5120;
  localparam logic signed [ACC_W-1:0] NEG_DRIVE_LIMIT = -40'sd5120;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 32'sh8000_0000;

  // 20.0 in the q8.8 gain times q16.16 integral format
  localparam logic [DIV_NUM_W-1:0] LIMIT_Q24 = DIV_NUM_W'(20 << 24);
  localparam logic signed [MUL_W-1:0] INTEG_LIMIT = MUL_W'(20 << 24);
  localparam logic signed [MUL_W-1:0] NEG_INTEG_LIMIT = -(MUL_W'(20 << 24));

  // reciprocals of 5, exact over the ranges they see
  localparam logic [MUL_B_W-1:0] RECIP5_Q18 = 22'd52429;
  localparam logic [MUL_B_W-1:0] RECIP5_Q24 = 22'd3355444;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd256;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd256;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd0;

endpackage
`default_nettype wire

// ----- rtl/core/sap_in_if.sv -----
// request channel carrying one potentiometer reading and target angle
`timescale 1ns / 1ps
`default_nettype none
interface sap_in_if;
  logic                                valid;
  logic                                ready;
  logic [sap_pkg::POT_W-1:0]           pot_reading;
  logic signed [sap_pkg::ANGLE_W-1:0]  target_angle;

  modport source (output valid, output pot_reading, output target_angle, input ready);
  modport sink   (input valid, input pot_reading, input target_angle, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sap_out_if.sv -----
// result channel carrying drive, measured angle, error and stop flag
`timescale 1ns / 1ps
`default_nettype none
interface sap_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sap_pkg::DRIVE_W-1:0]  drive;
  logic signed [sap_pkg::MEAS_W-1:0]   measured_angle;
  logic signed [sap_pkg::ANGLE_W-1:0]  angle_error;
  logic                                stopped;

  modport source (output valid, output drive, output measured_angle, output angle_error,
                  output stopped, input ready);
  modport sink   (input valid, input drive, input measured_angle, input angle_error,
                  input stopped, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sap_divider.sv -----
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module sap_divider #(
  parameter int NUM_W = sap_pkg::DIV_NUM_W,
  parameter int DEN_W = sap_pkg::GAIN_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] n_r, n_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             fits;

  always_comb begin
    rem_sh   = {rem_r, n_r[NUM_W-1]};
    diff     = rem_sh - {1'b0, den};
    fits     = !diff[DEN_W];
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (start) begin
      n_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      // quotient bits shift in where the dividend bits leave
      n_nxt   = {n_r[NUM_W-2:0], fits};
      rem_nxt = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = n_r;

  a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !done_r)
    else $error("divider done right after start");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && !start |=> done_r && $stable(n_r))
    else $error("divider result changed without a new start");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_W))
    else $error("divider step count out of range");

  a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> !done_r)
    else $error("divider done while still iterating");

endmodule
`default_nettype wire

// ----- rtl/core/servo_angle_pid_step_core.sv -----
// servo angle pid step: shared multiplier sequencer with serial divider
//
// one request on in_ch per control tick: a filtered 10-bit pot reading and a
// q8.8 target angle. one result per request on out_ch: q6.8 drive, q7.8 measured
// angle, q8.8 angle error and the sticky stop flag.
// gains are written through cfg_we/cfg_index/cfg_wdata while no request is
// in flight: index 0 proportional, 1 integral, 2 derivative (q8.8).
// the next request is taken only once the sequencer is back in idle. the
// sequencer waits in S_CLAMP for the 29-step serial divider that forms the
// integral limit; the other work (measure, integral step, pid products) runs
// through one 33x22 multiplier, at most one product per cycle, alongside the
// divider, which starts as the request is accepted.
// in_ch.ready is high only while the sequencer is idle, so one request is
// worked on at a time; a new request can be taken while a result still waits
// in the output register. if out_ch stalls, the sequencer holds the finished
// result in its last step and does not return to idle.
// reset (synchronous, active low) clears the integral, the prior error and the
// stop flag, loads the gains with 1.0, 1.0 and 0.0 and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module servo_angle_pid_step_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sap_in_if.sink                             in_ch,
  sap_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [sap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sap_pkg::GAIN_W-1:0]    cfg_wdata
);

  localparam int POT_W   = sap_pkg::POT_W;
  localparam int ANGLE_W = sap_pkg::ANGLE_W;
  localparam int GAIN_W  = sap_pkg::GAIN_W;
  localparam int INTEG_W = sap_pkg::INTEG_W;
  localparam int DERIV_W = sap_pkg::DERIV_W;
  localparam int MUL_A_W = sap_pkg::MUL_A_W;
  localparam int MUL_B_W = sap_pkg::MUL_B_W;
  localparam int MUL_W   = sap_pkg::MUL_W;
  localparam int ACC_W   = sap_pkg::ACC_W;
  localparam int DRIVE_W = sap_pkg::DRIVE_W;
  localparam int MEAS_W  = sap_pkg::MEAS_W;
  localparam int DIV_W   = sap_pkg::DIV_NUM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MEAS, S_ERR, S_IDIV, S_INTEG, S_PART, S_CLAMP, S_PT, S_IT, S_DT, S_SUM
  } state_t;

  function automatic logic signed [ACC_W-1:0] trunc_q8(input logic signed [MUL_W-1:0] p);
    logic signed [MUL_W-1:0] t;
    logic signed [MUL_W-1:0] s;
    t = p + (p[MUL_W-1] ? MUL_W'(255) : MUL_W'(0));
    s = t >>> 8;
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] trunc_q16(input logic signed [MUL_W-1:0] p);
    logic signed [MUL_W-1:0] t;
    logic signed [MUL_W-1:0] s;
    t = p + (p[MUL_W-1] ? MUL_W'(65535) : MUL_W'(0));
    s = t >>> 16;
    return s[ACC_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0] gain_p_r, gain_p_nxt;
  logic [GAIN_W-1:0] gain_i_r, gain_i_nxt;
  logic [GAIN_W-1:0] gain_d_r, gain_d_nxt;

  logic signed [INTEG_W-1:0] integral_r, integral_nxt;
  logic signed [ANGLE_W-1:0] prior_r, prior_nxt;
  logic                      stop_r, stop_nxt;

  logic [POT_W-1:0]          reading_r, reading_nxt;
  logic signed [ANGLE_W-1:0] target_r, target_nxt;
  logic                      tick_stop_r, tick_stop_nxt;
  logic signed [ANGLE_W-1:0] meas_r, meas_nxt;
  logic signed [ANGLE_W-1:0] err_r, err_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [DERIV_W-1:0] deriv_r, deriv_nxt;
  logic signed [MUL_W-1:0]   p_r, p_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic signed [MEAS_W-1:0]  meas_out_r, meas_out_nxt;
  logic signed [ANGLE_W-1:0] err_out_r, err_out_nxt;
  logic                      stopped_r, stopped_nxt;

  logic                      in_acc;
  logic                      div_done;
  logic [DIV_W-1:0]          div_quo;

  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [MUL_W-1:0]   prod;
  logic                      issue;

  logic                      bad;
  logic [POT_W-1:0]          rc;
  logic [POT_W-1:0]          xoff;
  logic [16:0]               n17;
  logic signed [ANGLE_W-1:0] meas_c;
  logic signed [ANGLE_W-1:0] tc;
  logic [ANGLE_W-1:0]        mag;
  logic signed [20:0]        step;
  logic signed [INTEG_W:0]   sum33;
  logic signed [16:0]        d17;
  logic signed [DERIV_W-1:0] dext;
  logic signed [INTEG_W-1:0] lim;
  logic signed [ACC_W-1:0]   total;
  logic signed [ACC_W-1:0]   sat;
  logic                      sum_fire;

  assign in_acc = in_ch.valid && in_ch.ready;

  sap_divider #(
    .NUM_W(DIV_W),
    .DEN_W(GAIN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .num   (sap_pkg::LIMIT_Q24),
    .den   (gain_i_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    issue = 1'b1;
    mag   = err_r[ANGLE_W-1] ? -err_r : err_r;
    case (state_r)
      S_MEAS: begin
        mul_a = $signed({16'b0, n17});
        mul_b = sap_pkg::RECIP5_Q18;
      end
      S_IDIV: begin
        mul_a = $signed({10'b0, mag, 7'b0});
        mul_b = sap_pkg::RECIP5_Q24;
      end
      S_PART, S_IT: begin
        mul_a = {integ_r[INTEG_W-1], integ_r};
        mul_b = {6'b0, gain_i_r};
      end
      S_PT: begin
        mul_a = {{(MUL_A_W-ANGLE_W){err_r[ANGLE_W-1]}}, err_r};
        mul_b = {6'b0, gain_p_r};
      end
      S_DT: begin
        mul_a = {{(MUL_A_W-DERIV_W){deriv_r[DERIV_W-1]}}, deriv_r};
        mul_b = {6'b0, gain_d_r};
      end
      default: begin
        issue = 1'b0;
      end
    endcase
    prod = mul_a * $signed({1'b0, mul_b});
  end

  always_comb begin
    state_nxt     = state_r;
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    integral_nxt  = integral_r;
    prior_nxt     = prior_r;
    stop_nxt      = stop_r;
    reading_nxt   = reading_r;
    target_nxt    = target_r;
    tick_stop_nxt = tick_stop_r;
    meas_nxt      = meas_r;
    err_nxt       = err_r;
    integ_nxt     = integ_r;
    deriv_nxt     = deriv_r;
    acc_nxt       = acc_r;
    p_nxt         = issue ? prod : p_r;
    drive_nxt     = drive_r;
    meas_out_nxt  = meas_out_r;
    err_out_nxt   = err_out_r;
    stopped_nxt   = stopped_r;
    sum_fire      = 1'b0;

    bad  = (reading_r < sap_pkg::POT_LO) || (reading_r > sap_pkg::POT_HI);
    rc   = (reading_r < sap_pkg::ADC_LO) ? sap_pkg::ADC_LO :
           (reading_r > sap_pkg::ADC_HI) ? sap_pkg::ADC_HI : reading_r;
    xoff = rc - sap_pkg::ADC_LO;
    // times 192 as two shifts
    n17  = ({7'b0, xoff} << 7) + ({7'b0, xoff} << 6);

    meas_c = $signed({1'b0, p_r[32:18]}) - sap_pkg::ANGLE_LIMIT;
    tc     = (target_r > sap_pkg::ANGLE_LIMIT) ? sap_pkg::ANGLE_LIMIT :
             (target_r < sap_pkg::NEG_ANGLE_LIMIT) ? sap_pkg::NEG_ANGLE_LIMIT : target_r;

    step  = err_r[ANGLE_W-1] ? -$signed({1'b0, p_r[43:24]}) : $signed({1'b0, p_r[43:24]});
    sum33 = {integral_r[INTEG_W-1], integral_r} + {{12{step[20]}}, step};
    d17   = {err_r[ANGLE_W-1], err_r} - {prior_r[ANGLE_W-1], prior_r};
    dext  = {{4{d17[16]}}, d17};
    lim   = $signed({3'b0, div_quo});

    total = acc_r + trunc_q8(p_r);
    sat   = (total > sap_pkg::DRIVE_LIMIT) ? sap_pkg::DRIVE_LIMIT :
            (total < sap_pkg::NEG_DRIVE_LIMIT) ? sap_pkg::NEG_DRIVE_LIMIT : total;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          reading_nxt = in_ch.pot_reading;
          target_nxt  = in_ch.target_angle;
          state_nxt   = S_MEAS;
        end
      end
      S_MEAS: begin
        tick_stop_nxt = stop_r || bad;
        state_nxt     = S_ERR;
      end
      S_ERR: begin
        meas_nxt  = meas_c;
        err_nxt   = tc - meas_c;
        state_nxt = S_IDIV;
      end
      S_IDIV: begin
        state_nxt = S_INTEG;
      end
      S_INTEG: begin
        if (sum33[INTEG_W] != sum33[INTEG_W-1]) begin
          integ_nxt = sum33[INTEG_W] ? sap_pkg::INTEG_MIN : sap_pkg::INTEG_MAX;
        end else begin
          integ_nxt = sum33[INTEG_W-1:0];
        end
        deriv_nxt = (dext <<< 3) + (dext <<< 1);
        state_nxt = S_PART;
      end
      S_PART: begin
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        // a zero integral gain gives a zero product, so no clamp applies
        if (div_done) begin
          if (p_r > sap_pkg::INTEG_LIMIT) begin
            integ_nxt = lim;
          end else if (p_r < sap_pkg::NEG_INTEG_LIMIT) begin
            integ_nxt = -lim;
          end
          state_nxt = S_PT;
        end
      end
      S_PT: begin
        state_nxt = S_IT;
      end
      S_IT: begin
        acc_nxt   = trunc_q8(p_r);
        state_nxt = S_DT;
      end
      S_DT: begin
        acc_nxt   = acc_r + trunc_q16(p_r);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (!out_valid_r || out_ch.ready) begin
          sum_fire     = 1'b1;
          meas_out_nxt = meas_r[MEAS_W-1:0];
          stopped_nxt  = tick_stop_r;
          stop_nxt     = tick_stop_r;
          if (tick_stop_r) begin
            drive_nxt   = '0;
            err_out_nxt = '0;
          end else begin
            err_out_nxt  = err_r;
            integral_nxt = integ_r;
            prior_nxt    = err_r;
            if (err_r > sap_pkg::NEG_DEADBAND && err_r < sap_pkg::DEADBAND) begin
              drive_nxt = '0;
            end else begin
              drive_nxt = sat[DRIVE_W-1:0];
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ch.ready) || sum_fire;

    if (cfg_we) begin
      case (cfg_index)
        sap_pkg::CFG_GAIN_P: gain_p_nxt = cfg_wdata;
        sap_pkg::CFG_GAIN_I: gain_i_nxt = cfg_wdata;
        sap_pkg::CFG_GAIN_D: gain_d_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_p_r    <= sap_pkg::GAIN_P_RST;
      gain_i_r    <= sap_pkg::GAIN_I_RST;
      gain_d_r    <= sap_pkg::GAIN_D_RST;
      integral_r  <= '0;
      prior_r     <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      integral_r  <= integral_nxt;
      prior_r     <= prior_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    reading_r   <= reading_nxt;
    target_r    <= target_nxt;
    tick_stop_r <= tick_stop_nxt;
    meas_r      <= meas_nxt;
    err_r       <= err_nxt;
    integ_r     <= integ_nxt;
    deriv_r     <= deriv_nxt;
    p_r         <= p_nxt;
    acc_r       <= acc_nxt;
    drive_r     <= drive_nxt;
    meas_out_r  <= meas_out_nxt;
    err_out_r   <= err_out_nxt;
    stopped_r   <= stopped_nxt;
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.drive          = drive_r;
  assign out_ch.measured_angle = meas_out_r;
  assign out_ch.angle_error    = err_out_r;
  assign out_ch.stopped        = stopped_r;

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("ready while a request is in progress");

  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && stopped_r |-> (drive_r == '0) && (err_out_r == '0))
    else $error("stopped result with nonzero drive or error");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (drive_r <= 14'sd5120) && (drive_r >= -14'sd5120))
    else $error("drive outside saturation limits");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("stop flag cleared without reset");

  a_deadband: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (err_out_r > sap_pkg::NEG_DEADBAND) && (err_out_r < sap_pkg::DEADBAND)
      |-> (drive_r == '0))
    else $error("nonzero drive inside deadband");

endmodule
`default_nettype wire

// ----- tb/sap_pid_checker.sv -----
// checker for the servo angle pid step block: predicts each tick and compares results
`timescale 1ns / 1ps
module sap_pid_checker
  import sap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  sap_in_if                    in_ch,
  sap_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   open_count
);

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [MEAS_W-1:0]  measured;
    logic signed [ANGLE_W-1:0] err;
    logic                      stopped;
  } tick_result_t;

  localparam longint POT_MIN   = POT_LO;
  localparam longint POT_MAX   = POT_HI;
  localparam longint ADC_MIN   = ADC_LO;
  localparam longint ADC_MAX   = ADC_HI;
  localparam longint ANG_LIM   = ANGLE_LIMIT;
  localparam longint DEAD_LIM  = DEADBAND;
  localparam longint DRV_LIM   = DRIVE_LIMIT;
  localparam longint SUM_MAX   = INTEG_MAX;
  localparam longint SUM_MIN   = INTEG_MIN;
  localparam longint PART_LIM  = INTEG_LIMIT;
  localparam longint TICK_RATE = 10;  // 0.1 s control interval

  logic [GAIN_W-1:0]         kp, ki, kd;
  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [ANGLE_W-1:0] last_err;
  logic                      halted;
  tick_result_t              predicted_ticks[$];

  function automatic tick_result_t next_pid_result(input logic [POT_W-1:0] pot,
                                                   input logic signed [ANGLE_W-1:0] tgt);
    longint rd, meas, tg, err, integ, deriv, lim, gp, gi, gd, drv;
    tick_result_t r;
    rd = pot;
    gp = kp;
    gi = ki;
    gd = kd;
    err = 0;
    drv = 0;
    if (rd < POT_MIN || rd > POT_MAX) halted = 1'b1;
    meas = (rd < ADC_MIN) ? ADC_MIN : (rd > ADC_MAX) ? ADC_MAX : rd;
    meas = (meas - ADC_MIN) * (2 * ANG_LIM) / (ADC_MAX - ADC_MIN) - ANG_LIM;
    if (!halted) begin
      tg = tgt;
      if (tg > ANG_LIM) tg = ANG_LIM;
      if (tg < -ANG_LIM) tg = -ANG_LIM;
      err = tg - meas;
      integ = longint'(integ_acc) + (err * 256) / TICK_RATE;
      if (integ > SUM_MAX) integ = SUM_MAX;
      if (integ < SUM_MIN) integ = SUM_MIN;
      deriv = (err - longint'(last_err)) * TICK_RATE;
      // anti-windup: keep ki * integral within the drive limit
      if (gi != 0) begin
        lim = PART_LIM / gi;
        if (gi * integ > PART_LIM) integ = lim;
        else if (gi * integ < -PART_LIM) integ = -lim;
      end
      integ_acc = INTEG_W'(integ);
      drv = (gp * err) / 256 + (gi * integ) / 65536 + (gd * deriv) / 256;
      if (drv > DRV_LIM) drv = DRV_LIM;
      if (drv < -DRV_LIM) drv = -DRV_LIM;
      last_err = ANGLE_W'(err);
      if (err > -DEAD_LIM && err < DEAD_LIM) drv = 0;
    end
    r.drive    = DRIVE_W'(drv);
    r.measured = MEAS_W'(meas);
    r.err      = ANGLE_W'(err);
    r.stopped  = halted;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tick_result_t want;
    int bad;
    if (!rst_n) begin
      kp <= GAIN_P_RST;
      ki <= GAIN_I_RST;
      kd <= GAIN_D_RST;
      integ_acc = '0;
      last_err = '0;
      halted = 1'b0;
      predicted_ticks.delete();
      fail_count <= 0;
      open_count <= 0;
    end else begin
      bad = 0;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_GAIN_P: kp <= cfg_wdata;
          CFG_GAIN_I: ki <= cfg_wdata;
          CFG_GAIN_D: kd <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_ticks.size() == 0) begin
          $display("%0t: result with no request pending: drive %0d measured %0d error %0d",
                   $time, out_ch.drive, out_ch.measured_angle, out_ch.angle_error);
          bad++;
        end else begin
          want = predicted_ticks.pop_front();
          if (out_ch.drive !== want.drive) begin
            $display("%0t: drive expected %0d got %0d", $time, want.drive, out_ch.drive);
            bad++;
          end
          if (out_ch.measured_angle !== want.measured) begin
            $display("%0t: measured_angle expected %0d got %0d", $time, want.measured,
                     out_ch.measured_angle);
            bad++;
          end
          if (out_ch.angle_error !== want.err) begin
            $display("%0t: angle_error expected %0d got %0d", $time, want.err,
                     out_ch.angle_error);
            bad++;
          end
          if (out_ch.stopped !== want.stopped) begin
            $display("%0t: stopped expected %0b got %0b", $time, want.stopped,
                     out_ch.stopped);
            bad++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predicted_ticks.push_back(next_pid_result(in_ch.pot_reading, in_ch.target_angle));
      fail_count <= fail_count + bad;
      open_count <= predicted_ticks.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// top of the servo angle pid step testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import sap_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 40;  // wait after the last result is taken
  localparam int RAND_PHASES = 8;
  localparam int PHASE_TICKS = 210;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_wdata;
  int                   fail_count;
  int                   open_count;
  int                   cycle_count = 0;
  int                   stall_left = 0;
  logic                 stalls_on = 1'b1;
  logic                 gaps_on = 1'b1;

  sap_in_if  in_ch ();
  sap_out_if out_ch ();

  servo_angle_pid_step_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sap_pid_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (stalls_on && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  function automatic logic [GAIN_W-1:0] pick_gain(input int floor);
    int g;
    case ($urandom_range(0, 7))
      0: g = floor;
      1: g = 65535;
      2, 3, 4: g = $urandom_range(0, 512);
      5, 6: g = $urandom_range(0, 4096);
      default: g = $urandom_range(0, 65535);
    endcase
    if (g < floor) g = floor;
    return GAIN_W'(g);
  endfunction

  // entered and left at a falling edge; valid stays high after the request
  task automatic send_tick(input logic [POT_W-1:0] pot, input logic signed [ANGLE_W-1:0] tgt,
                           input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pot_reading  <= pot;
    in_ch.target_angle <= tgt;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_random_tick();
    logic [POT_W-1:0]          pot;
    logic signed [ANGLE_W-1:0] tgt;
    int                        r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      // near mid scale with a small target, around the deadband
      pot = $urandom_range(480, 520);
      tgt = ANGLE_W'($urandom_range(0, 1600)) - 16'sd800;
    end else begin
      if (r < 30) pot = ($urandom_range(0, 1) == 1) ? $urandom_range(180, 220)
                                                    : $urandom_range(780, 820);
      else pot = $urandom_range(POT_LO, POT_HI);
      if (r < 75) tgt = ANGLE_W'($urandom_range(0, 23040)) - ANGLE_LIMIT;
      else tgt = ANGLE_W'($urandom_range(0, 65535));
    end
    send_tick(pot, tgt, gaps_on ? pick_gap() : 0);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (open_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                           input logic [GAIN_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAIN_P;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_index <= CFG_GAIN_I;
    cfg_wdata <= i;
    @(negedge clk);
    cfg_index <= CFG_GAIN_D;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_GAIN_P;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.pot_reading  = '0;
    in_ch.target_angle = '0;
    out_ch.ready       = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset gains: scale ends, target clamps, reading clamps, deadband edges
    send_tick(500, 0, 0);
    send_tick(200, 32767, 0);
    send_tick(800, -32768, 0);
    send_tick(50, 11520, 0);
    send_tick(1000, -11520, 0);
    send_tick(199, 0, 0);
    send_tick(801, 0, 0);
    send_tick(500, 511, 0);
    send_tick(500, 512, 0);
    send_tick(500, -511, 0);
    send_tick(500, -512, 0);

    wait_idle();
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(200, 11520, 0);
    send_tick(800, -11520, 0);
    send_tick(500, 0, 0);
    send_tick(350, 1000, 0);

    // zero integral gain: no windup clamp at all
    wait_idle();
    set_gains(0, 0, 0);
    send_tick(200, 11520, 0);
    send_tick(200, 11520, 0);
    send_tick(200, 11520, 0);
    send_tick(800, -11520, 0);

    wait_idle();
    set_gains(256, 1, 256);
    send_tick(200, 11520, 0);
    send_tick(200, 11520, 0);
    send_tick(500, -32768, 0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      set_gains(pick_gain(0), pick_gain(1), pick_gain(0));
      gaps_on   = (ph % 4 != 3);
      stalls_on = (ph % 4 != 2);
      for (int n = 0; n < PHASE_TICKS; n++) send_random_tick();
    end

    // sticky stop comes last since only reset clears it
    stalls_on = 1'b1;
    gaps_on   = 1'b1;
    send_tick(1001, 2000, 0);
    send_tick(500, 4000, 0);
    send_tick(1023, -4000, 1);
    send_tick(0, 0, 0);
    send_tick(49, 11520, 0);
    for (int n = 0; n < 30; n++)
      send_tick($urandom_range(0, 1023), ANGLE_W'($urandom_range(0, 65535)), pick_gap());

    wait_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
